[design/crcdefr_pkg.sv]
// Shared types, constants and CRC helpers for the CRC-16 response deframer.
package crcdefr_pkg;

	localparam int MAX_FRAME_BYTES = 256;
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int LEN_W = 9;

	localparam logic [7:0] CR_BYTE    = 8'h0d;
	localparam logic [7:0] LF_BYTE    = 8'h0a;
	localparam logic [7:0] START_BYTE = 8'h28;

	// CRC-16 with polynomial 0x1021, one nibble per lookup
	localparam logic [15:0] NIB_TAB [16] = '{
		16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50a5, 16'h60c6, 16'h70e7,
		16'h8108, 16'h9129, 16'ha14a, 16'hb16b, 16'hc18c, 16'hd1ad, 16'he1ce, 16'hf1ef
	};

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_CRC_BAD   = 3'd1,
		ST_START_BAD = 3'd2,
		ST_SHORT     = 3'd3,
		ST_LONG      = 3'd4
	} status_t;

	typedef struct packed {
		logic             frame_end;
		logic [7:0]       payload_byte;
		status_t          frame_status;
		logic [LEN_W-1:0] payload_length;
		logic [15:0]      expected_check;
	} result_t;

	function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
		logic [3:0] idx;
		idx = crc[15:12] ^ nib;
		return {crc[11:0], 4'h0} ^ NIB_TAB[idx];
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] mid;
		mid = crc_nibble(crc, b[7:4]);
		return crc_nibble(mid, b[3:0]);
	endfunction

	// raise a check byte that would collide with a framing character
	function automatic logic [7:0] bump(input logic [7:0] b);
		if (b == START_BYTE || b == CR_BYTE || b == LF_BYTE) begin
			return b + 8'd1;
		end
		return b;
	endfunction

endpackage

[design/crcdefr_in_stage.sv]
// Input register stage of the deframer: holds one received word.
module crcdefr_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import crcdefr_pkg::*;

	// accept when empty or when the held word moves on this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

[design/crcdefr_engine.sv]
// Frame state, CRC update and result register of the deframer.
module crcdefr_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  logic [7:0]           byte_s1,
	output logic                 take,
	output logic                 out_valid,
	input  logic                 out_ready,
	output crcdefr_pkg::result_t res
);
	import crcdefr_pkg::*;

	logic [15:0]      crc_q, crc_d;
	logic [7:0]       dly0_q, dly0_d, dly1_q, dly1_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             start_q, start_d;
	logic             out_valid_q;
	result_t          res_q, res_d;
	logic             emit, clear, step;
	logic             is_cr, too_long, too_short;
	logic [15:0]      crc_adj, got;

	assign take = !out_valid_q || out_ready;
	assign step = valid_s1 && take;

	always_comb begin
		is_cr     = byte_s1 == CR_BYTE;
		too_short = cnt_q < CNT_W'(3);
		too_long  = !is_cr && (cnt_q >= CNT_W'(MAX_FRAME_BYTES));
		crc_adj   = {bump(crc_q[15:8]), bump(crc_q[7:0])};
		got       = {dly0_q, dly1_q};
		res_d     = '0;
		emit      = 1'b0;
		clear     = 1'b0;
		crc_d     = crc_q;
		dly0_d    = dly0_q;
		dly1_d    = dly1_q;
		cnt_d     = cnt_q;
		start_d   = start_q;
		if (is_cr) begin
			emit = 1'b1;
			clear = 1'b1;
			res_d.frame_end = 1'b1;
			if (too_short) begin
				res_d.frame_status = ST_SHORT;
			end else begin
				// checksum mismatch outranks a bad start byte
				if (crc_adj != got) begin
					res_d.frame_status = ST_CRC_BAD;
				end else if (!start_q) begin
					res_d.frame_status = ST_START_BAD;
				end else begin
					res_d.frame_status = ST_OK;
				end
				res_d.payload_length = LEN_W'(cnt_q - CNT_W'(3));
				res_d.expected_check = crc_adj;
			end
		end else if (too_long) begin
			// drop the word and resynchronize
			emit = 1'b1;
			clear = 1'b1;
			res_d.frame_end = 1'b1;
			res_d.frame_status = ST_LONG;
			res_d.payload_length = LEN_W'(cnt_q - CNT_W'(3));
		end else begin
			if (cnt_q == '0) begin
				start_d = byte_s1 == START_BYTE;
			end
			// hash the word leaving the delay line; confirm it once past the start byte
			if (cnt_q >= CNT_W'(2)) begin
				crc_d = crc_byte(crc_q, dly0_q);
			end
			if (cnt_q >= CNT_W'(3)) begin
				emit = 1'b1;
				res_d.payload_byte = dly0_q;
			end
			dly0_d = dly1_q;
			dly1_d = byte_s1;
			cnt_d  = cnt_q + CNT_W'(1);
		end
		if (clear) begin
			crc_d   = '0;
			dly0_d  = '0;
			dly1_d  = '0;
			cnt_d   = '0;
			start_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '0;
			dly0_q      <= '0;
			dly1_q      <= '0;
			cnt_q       <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				crc_q   <= crc_d;
				dly0_q  <= dly0_d;
				dly1_q  <= dly1_d;
				cnt_q   <= cnt_d;
				start_q <= start_d;
			end
			if (take) begin
				out_valid_q <= step && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_FRAME_BYTES))
		else $error("frame count beyond maximum frame length");

	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit && res_d.frame_end) |=> (cnt_q == '0 && crc_q == '0 && !start_q))
		else $error("frame state not cleared after status word");

	a_payload_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit && !res_d.frame_end) |-> (cnt_q >= CNT_W'(3)))
		else $error("payload word emitted before delay line filled");

	a_status_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.frame_end) |-> (res_q.payload_byte == 8'h00))
		else $error("status word carries a payload byte");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(cnt_q) && $stable(crc_q)))
		else $error("frame state moved while output stalled");

endmodule

[design/crc16_response_deframer.sv]
// Top level of the CRC-16 framed response deframer.
//
// Input channel: one received word (rx_byte) per in_valid/in_ready transfer.
// A frame is '(' then payload, two check words (high first), then CR (0x0d).
// Output channel: out_valid/out_ready; frame_end=0 carries one confirmed
// payload word, frame_end=1 carries the frame status, payload length and
// the adjusted CRC-16 (poly 0x1021, init 0) computed over the frame.
// Payload words leave two words behind the input, so check words are never
// hashed; payload is not recalled when the frame later fails.
// A result is registered after its word has passed the input register.
// Throughput: one word per cycle unless out_ready stalls the output; the byte
// CRC update (two table lookups) lies between the input and result registers.
// Reset clears frame state, both registers' valid flags; the first word
// after reset starts a new frame. When out_ready is low with a result held,
// at most one more word is stored in the input register, then in_ready drops.
module crc16_response_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_end,
	output logic [7:0]  payload_byte,
	output logic [2:0]  frame_status,
	output logic [8:0]  payload_length,
	output logic [15:0] expected_check
);
	import crcdefr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       take;
	result_t    res;

	crcdefr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	crcdefr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign frame_end      = res.frame_end;
	assign payload_byte   = res.payload_byte;
	assign frame_status   = 3'(res.frame_status);
	assign payload_length = res.payload_length;
	assign expected_check = res.expected_check;

endmodule
